// ===== rtl/json_string_escaper_macros.svh =====
// Assertion macros shared by the JSON string escaper RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef JSON_STRING_ESCAPER_MACROS_SVH
`define JSON_STRING_ESCAPER_MACROS_SVH
`ifndef ASSERT_OFF
// Property checked on every rising edge of the clock, disabled while reset is high.
`define JSE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Property checked on every rising edge of the clock, reset included.
`define JSE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define JSE_ASSERT(lbl, clk, rst, prop, msg)
`define JSE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/jse_pkg.sv =====
// Package for the JSON string escaper: transaction structs, command codes,
// queue entry type and the hex digit lookup. No dependencies.
package jse_pkg;

  // Command codes carried in the cmd field of an input transaction.
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_DATA  = 2'd1;
  localparam logic [1:0] CMD_END   = 2'd2;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_item_t;

  // How a queued entry is to be written out.
  typedef enum logic [1:0] {
    KIND_PLAIN,    // one byte, as stored
    KIND_SHORT,    // backslash then the stored escape letter
    KIND_UNICODE   // backslash, u, 0, 0 and two hex digits of the stored byte
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] ch;
  } entry_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    if (nib < 4'd10) begin
      d = 8'h30 + {4'd0, nib};
    end else begin
      d = 8'h57 + {4'd0, nib};
    end
    return d;
  endfunction

endpackage

// ===== rtl/json_string_escaper.sv =====
// Top level of the JSON string escaper: front end, entry queue and back end.
// Depends on jse_pkg, jse_front, jse_queue, jse_back.
//
//   Channel   Handshake          Payload                    Direction
//   -------   ----------------   ------------------------   ---------
//   command   start / busy       item (cmd, data_byte)      in
//   result    strobe             result (out_byte, run_last) out
//
// A command transaction is taken on a rising edge with start high and busy
// low. Its bytes pass the queue, current entry and result register. Ordinary
// bytes and quotes give one output byte each, so such a stream runs at one
// transaction per cycle; a short escape gives two output bytes and a \u00XX
// escape six, the back end serialiser emitting one byte per cycle. The entry
// queue (QUEUE_DEPTH deep) absorbs transactions during escapes; busy rises
// only when it is full. The receiver cannot stall: every strobe is one
// result. Reset (synchronous, active high) empties the queue and drops any
// run in progress; an unused command code is accepted and produces nothing.
module json_string_escaper #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  jse_pkg::in_item_t  item,
  output logic               busy,
  output logic               strobe,
  output jse_pkg::out_item_t result
);
  import jse_pkg::*;

  logic   push;
  logic   pop;
  logic   queue_full;
  logic   queue_empty;
  entry_t wr_entry;
  entry_t head;

  // Front end: classification of each accepted command into a queue entry.
  jse_front u_front (
    .start      (start),
    .item       (item),
    .queue_full (queue_full),
    .busy       (busy),
    .push       (push),
    .entry      (wr_entry)
  );

  // Decoupling queue, so that an escape on the output side does not stop
  // the command side until the queue fills.
  jse_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .full     (queue_full),
    .empty    (queue_empty),
    .head     (head)
  );

  // Back end: byte serialiser with a registered result port.
  jse_back u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (queue_empty),
    .head   (head),
    .pop    (pop),
    .strobe (strobe),
    .result (result)
  );

endmodule

// ===== rtl/jse_front.sv =====
// Front end of the JSON string escaper: accepts command transactions and
// classifies each into a queue entry. Depends on jse_pkg.
module jse_front (
  input  logic              start,
  input  jse_pkg::in_item_t item,
  input  logic              queue_full,
  output logic              busy,
  output logic              push,
  output jse_pkg::entry_t   entry
);
  import jse_pkg::*;

  logic accept;

  assign busy   = queue_full;
  assign accept = start && !queue_full;

  always_comb begin
    entry.kind = KIND_PLAIN;
    entry.ch   = item.data_byte;
    push       = accept;
    unique case (item.cmd)
      CMD_START, CMD_END: begin
        entry.ch = CH_QUOTE;
      end
      CMD_DATA: begin
        unique case (item.data_byte)
          8'h22:   begin entry.kind = KIND_SHORT; entry.ch = CH_QUOTE;  end
          8'h5C:   begin entry.kind = KIND_SHORT; entry.ch = CH_BSLASH; end
          8'h08:   begin entry.kind = KIND_SHORT; entry.ch = 8'h62;     end
          8'h0C:   begin entry.kind = KIND_SHORT; entry.ch = 8'h66;     end
          8'h0A:   begin entry.kind = KIND_SHORT; entry.ch = 8'h6E;     end
          8'h0D:   begin entry.kind = KIND_SHORT; entry.ch = 8'h72;     end
          8'h09:   begin entry.kind = KIND_SHORT; entry.ch = 8'h74;     end
          default: begin
            if (item.data_byte < CTRL_LIMIT) begin
              entry.kind = KIND_UNICODE;
            end
          end
        endcase
      end
      default: begin
        // The unused command is taken but produces nothing.
        push = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/jse_queue.sv =====
// Small register queue between the escaper front and back ends.
// Depends on jse_pkg and the assertion macro header.
`include "json_string_escaper_macros.svh"
module jse_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  jse_pkg::entry_t wr_entry,
  input  logic            pop,
  output logic            full,
  output logic            empty,
  output jse_pkg::entry_t head
);
  import jse_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `JSE_ASSERT(a_no_overflow, clk, rst, push |-> !full, "write into a full queue")
  `JSE_ASSERT(a_no_underflow, clk, rst, pop |-> !empty, "read from an empty queue")
  `JSE_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(DEPTH), "queue fill out of range")

endmodule

// ===== rtl/jse_back.sv =====
// Back end of the JSON string escaper: serialises queue entries into output
// bytes, one per cycle, behind an output register. Depends on jse_pkg.
`include "json_string_escaper_macros.svh"
module jse_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                empty,
  input  jse_pkg::entry_t     head,
  output logic                pop,
  output logic                strobe,
  output jse_pkg::out_item_t  result
);
  import jse_pkg::*;

  entry_t     cur;
  logic       cur_valid;
  logic [2:0] idx;
  logic [2:0] last_idx;
  logic       at_last;
  logic       advance;
  logic [7:0] byte_now;

  always_comb begin
    unique case (cur.kind)
      KIND_PLAIN:   last_idx = 3'd0;
      KIND_SHORT:   last_idx = 3'd1;
      KIND_UNICODE: last_idx = 3'd5;
      default:      last_idx = 3'd0;
    endcase
  end

  assign at_last = (idx == last_idx);
  assign advance = !cur_valid || at_last;
  assign pop     = advance && !empty;

  always_comb begin
    byte_now = cur.ch;
    unique case (cur.kind)
      KIND_PLAIN: begin
        byte_now = cur.ch;
      end
      KIND_SHORT: begin
        byte_now = (idx == 3'd0) ? CH_BSLASH : cur.ch;
      end
      KIND_UNICODE: begin
        unique case (idx)
          3'd0:    byte_now = CH_BSLASH;
          3'd1:    byte_now = CH_U;
          3'd2,
          3'd3:    byte_now = CH_ZERO;
          3'd4:    byte_now = hex_digit(cur.ch[7:4]);
          3'd5:    byte_now = hex_digit(cur.ch[3:0]);
          default: byte_now = CH_ZERO;
        endcase
      end
      default: byte_now = cur.ch;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    result.out_byte <= byte_now;
    result.run_last <= at_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
      strobe    <= 1'b0;
    end else begin
      strobe <= cur_valid;
      if (advance) begin
        cur_valid <= !empty;
        idx       <= '0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  `JSE_ASSERT(a_idx_bound, clk, rst, cur_valid |-> (idx <= last_idx), "run index past its end")
  `JSE_ASSERT(a_idx_held, clk, rst, !cur_valid |-> (idx == 3'd0), "index moved with no entry")
  `JSE_ASSERT(a_run_continues, clk, rst, (cur_valid && !at_last) |=> (cur_valid && idx != 3'd0), "run cut short")

endmodule
